>>> rtl/ctt_pkg.sv
// shared types, constants and field positions for the capacitive touch timer
package ctt_pkg;

    localparam int TOTAL_WIDTH_DEF = 28;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT  = 2'd0,
        CFG_AUTOCAL  = 2'd1,
        CFG_DISCHRG  = 2'd2
    } t_cfg_idx;

    localparam logic [23:0] TIMEOUT_RST = 24'd620000;
    localparam logic [15:0] AUTOCAL_RST = 16'd20000;
    localparam logic [15:0] DISCHRG_RST = 16'd160;

    localparam logic [31:0] BASE_INIT_VALUE = 32'h0FFF_FFFF;
    localparam logic [16:0] MS_MAX          = 17'h1_FFFF;

    localparam int READING_W = 28;

    // input tdata: sample_count, rx_level, ms_tick; tuser: action
    localparam int S_TDATA_W  = 16;
    localparam int S_COUNT_LO = 0;
    localparam int S_RX_BIT   = 8;
    localparam int S_MS_BIT   = 9;

    // output tdata: send_level, rx_drive_enable, rx_drive_level, done_res, status, reading
    localparam int M_TDATA_W   = 40;
    localparam int M_SEND_BIT  = 0;
    localparam int M_DREN_BIT  = 1;
    localparam int M_DRLV_BIT  = 2;
    localparam int M_DONE_BIT  = 3;
    localparam int M_STAT_BIT  = 4;
    localparam int M_READ_LO   = 5;
    localparam int M_READ_HI   = M_READ_LO + READING_W - 1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DISCH  = 3'd1,
        PH_CHARGE = 3'd2,
        PH_PULSE  = 3'd3,
        PH_HIGH   = 3'd4
    } t_phase;

    typedef struct packed {
        logic                 send_level;
        logic                 rx_drive_enable;
        logic                 rx_drive_level;
        logic                 done_res;
        logic                 status;
        logic [READING_W-1:0] reading;
    } t_result;

endpackage

>>> rtl/ctt_cal_window.sv
// baseline recalibration window: floor(baseline/10) by reciprocal, then low and high bounds
module ctt_cal_window #(
    parameter int TOTAL_WIDTH = ctt_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic [TOTAL_WIDTH-1:0] i_baseline,
    output logic [TOTAL_WIDTH-1:0] o_win_lo,
    output logic [TOTAL_WIDTH:0]   o_win_hi
);
    import ctt_pkg::*;

    localparam int W = TOTAL_WIDTH;
    localparam int SHIFT = W + 4;
    // ceil(2^SHIFT / 10); error stays below 1/16 of one step for any W-bit value
    localparam logic [W:0] RECIP = (W + 1)'(((64'd1 << SHIFT) + 64'd9) / 64'd10);

    logic [2*W:0] r_prod;
    logic [2*W:0] n_prod;
    logic [W-1:0] r_base_d;
    logic [W-1:0] w_div10;
    logic [W-1:0] r_win_lo;
    logic [W:0]   r_win_hi;

    assign n_prod  = (2*W + 1)'(i_baseline) * (2*W + 1)'(RECIP);
    assign w_div10 = {3'b000, r_prod[2*W:SHIFT]};

    // free running: a finish is always several items after the last baseline change
    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_base_d <= i_baseline;
        r_win_lo <= r_base_d - w_div10;
        r_win_hi <= {1'b0, r_base_d} + {1'b0, w_div10};
    end

    assign o_win_lo = r_win_lo;
    assign o_win_hi = r_win_hi;

endmodule

>>> rtl/ctt_fsm.sv
// measurement sequencer: phases, tick total, baseline tracking and config registers
module ctt_fsm #(
    parameter int TOTAL_WIDTH = ctt_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ctt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ctt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_accept,
    input  logic                             i_action,
    input  logic [7:0]                       i_sample_count,
    input  logic                             i_rx_level,
    input  logic                             i_ms_tick,
    input  logic [TOTAL_WIDTH-1:0]           i_win_lo,
    input  logic [TOTAL_WIDTH:0]             i_win_hi,
    output logic [TOTAL_WIDTH-1:0]           o_baseline,
    output ctt_pkg::t_result                 o_result
);
    import ctt_pkg::*;

    localparam int W = TOTAL_WIDTH;
    localparam logic [W-1:0] BASE_INIT = BASE_INIT_VALUE[W-1:0];

    logic [23:0] r_timeout;
    logic [15:0] r_autocal;
    logic [15:0] r_dischrg;

    t_phase       r_phase, n_phase;
    logic [W-1:0] r_total, n_total;
    logic [W-1:0] r_baseline, n_baseline;
    logic [7:0]   r_samples, n_samples;
    logic [15:0]  r_timer, n_timer;
    logic [16:0]  r_ms, n_ms;

    logic         ev_done;
    logic         ev_timeout;
    logic [W-1:0] w_reading;

    logic [W-1:0] w_total_inc;
    logic         w_hit_cur;
    logic         w_hit_inc;
    logic [15:0]  w_timer_inc;

    assign w_total_inc = r_total + W'(1);
    assign w_timer_inc = r_timer + 16'd1;
    assign w_hit_cur = ({24'b0, r_total} >= {{W{1'b0}}, r_timeout}) || (&r_total);
    assign w_hit_inc = ({24'b0, w_total_inc} >= {{W{1'b0}}, r_timeout}) || (&w_total_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_autocal <= AUTOCAL_RST;
            r_dischrg <= DISCHRG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_AUTOCAL: r_autocal <= i_cfg_data[15:0];
                CFG_DISCHRG: r_dischrg <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_total    <= '0;
            r_baseline <= BASE_INIT;
            r_samples  <= '0;
            r_timer    <= '0;
            r_ms       <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_total    <= n_total;
            r_baseline <= n_baseline;
            r_samples  <= n_samples;
            r_timer    <= n_timer;
            r_ms       <= n_ms;
        end
    end

    // next state
    always_comb begin
        logic [W-1:0] base_cand;
        logic         recal;
        n_phase    = r_phase;
        n_total    = r_total;
        n_baseline = r_baseline;
        n_samples  = r_samples;
        n_timer    = r_timer;
        n_ms       = (i_ms_tick && (r_ms != MS_MAX)) ? r_ms + 17'd1 : r_ms;
        ev_done    = 1'b0;
        ev_timeout = 1'b0;
        w_reading  = '0;
        base_cand  = r_baseline;
        recal      = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_action) begin
                    n_total = '0;
                    if (i_sample_count == 8'd0) begin
                        ev_done = 1'b1;
                    end else begin
                        n_samples = i_sample_count;
                        n_timer   = '0;
                        n_phase   = PH_DISCH;
                    end
                end
            end
            PH_DISCH: begin
                n_timer = w_timer_inc;
                // a discharge time of zero behaves as one tick
                if (w_timer_inc >= r_dischrg || w_timer_inc == 16'd0) begin
                    n_phase = PH_CHARGE;
                end
            end
            PH_CHARGE: begin
                if (w_hit_cur) begin
                    ev_done = 1'b1; ev_timeout = 1'b1; n_phase = PH_IDLE;
                end else if (!i_rx_level) begin
                    n_total = w_total_inc;
                    if (w_hit_inc) begin
                        ev_done = 1'b1; ev_timeout = 1'b1; n_phase = PH_IDLE;
                    end
                end else begin
                    n_phase = PH_PULSE;
                end
            end
            PH_PULSE: begin
                n_phase = PH_HIGH;
            end
            PH_HIGH: begin
                if (w_hit_cur) begin
                    ev_done = 1'b1; ev_timeout = 1'b1; n_phase = PH_IDLE;
                end else if (i_rx_level) begin
                    n_total = w_total_inc;
                    if (w_hit_inc) begin
                        ev_done = 1'b1; ev_timeout = 1'b1; n_phase = PH_IDLE;
                    end
                end else begin
                    n_samples = r_samples - 8'd1;
                    if (r_samples == 8'd1) begin
                        ev_done = 1'b1;
                        n_phase = PH_IDLE;
                        // |total - baseline| < baseline/10 as an open window around baseline
                        recal = (n_ms > {1'b0, r_autocal}) && (r_total > i_win_lo)
                                && ({1'b0, r_total} < i_win_hi);
                        if (recal) begin
                            n_ms      = '0;
                            base_cand = BASE_INIT;
                        end
                        n_baseline = (r_total < base_cand) ? r_total : base_cand;
                        w_reading  = r_total - n_baseline;
                    end else begin
                        n_timer = '0;
                        n_phase = PH_DISCH;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // outputs: pin levels follow the phase in force after this item
    always_comb begin
        logic [W+READING_W-1:0] read_ext;
        read_ext                 = {{READING_W{1'b0}}, w_reading};
        o_result.send_level      = (n_phase == PH_CHARGE);
        o_result.rx_drive_enable = n_phase inside {PH_DISCH, PH_PULSE};
        o_result.rx_drive_level  = (n_phase == PH_PULSE);
        o_result.done_res        = ev_done;
        o_result.status          = ev_timeout;
        o_result.reading         = read_ext[READING_W-1:0];
    end

    assign o_baseline = r_baseline;

endmodule

>>> rtl/ctt_out_reg.sv
// result register between the sequencer and the output stream
module ctt_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ctt_pkg::t_result i_result,
    input  logic             i_m_tready,
    output logic             o_valid,
    output ctt_pkg::t_result o_result,
    output logic             o_in_ready
);
    import ctt_pkg::*;

    logic    r_valid;
    t_result r_result;

    // a new item may enter while the held result leaves in the same cycle
    assign o_in_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/capacitive_touch_timer.sv
// top level of the capacitive touch timer: streams, config port and submodules
// a result is registered and becomes valid in the cycle after its item is accepted
// throughput: one item per cycle; an item is taken whenever the result register is empty
// or its result is taken in the same cycle, so the single result register sets the rate
// reset: synchronous active low; clears phase, counters and config to defaults and sets
// the baseline to all ones (0x0FFFFFFF within the total width); no clearing pass
module capacitive_touch_timer #(
    parameter int TOTAL_WIDTH = ctt_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ctt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ctt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample_count [7:0], rx_level [8], ms_tick [9], zero [15:10]
    input  logic [ctt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // send_level [0], rx_drive_enable [1], rx_drive_level [2], done_res [3], status [4],
    // reading [32:5], zero [39:33]
    output logic [ctt_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import ctt_pkg::*;

    logic                   w_accept;
    logic [TOTAL_WIDTH-1:0] w_baseline;
    logic [TOTAL_WIDTH-1:0] w_win_lo;
    logic [TOTAL_WIDTH:0]   w_win_hi;
    t_result                w_result;
    t_result                w_out;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    ctt_cal_window #(
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_cal_window (
        .i_clk      (i_clk),
        .i_baseline (w_baseline),
        .o_win_lo   (w_win_lo),
        .o_win_hi   (w_win_hi)
    );

    ctt_fsm #(
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (w_accept),
        .i_action       (s_axis_tuser),
        .i_sample_count (s_axis_tdata[S_COUNT_LO +: 8]),
        .i_rx_level     (s_axis_tdata[S_RX_BIT]),
        .i_ms_tick      (s_axis_tdata[S_MS_BIT]),
        .i_win_lo       (w_win_lo),
        .i_win_hi       (w_win_hi),
        .o_baseline     (w_baseline),
        .o_result       (w_result)
    );

    ctt_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_result   (w_result),
        .i_m_tready (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_result   (w_out),
        .o_in_ready (s_axis_tready)
    );

    always_comb begin
        m_axis_tdata                        = '0;
        m_axis_tdata[M_SEND_BIT]            = w_out.send_level;
        m_axis_tdata[M_DREN_BIT]            = w_out.rx_drive_enable;
        m_axis_tdata[M_DRLV_BIT]            = w_out.rx_drive_level;
        m_axis_tdata[M_DONE_BIT]            = w_out.done_res;
        m_axis_tdata[M_STAT_BIT]            = w_out.status;
        m_axis_tdata[M_READ_HI:M_READ_LO]   = w_out.reading;
    end

endmodule

>>> rtl/ctt_checker.sv
// port-level checks for the capacitive touch timer, bound to the top level
module ctt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ctt_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import ctt_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an empty result register never blocks the input side
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result pending");

    // timeout status and a nonzero reading only come with done
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[M_STAT_BIT] || m_axis_tdata[M_READ_HI:M_READ_LO] != '0)
        |-> m_axis_tdata[M_DONE_BIT])
        else $error("status or reading without done");

    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[M_STAT_BIT] |-> m_axis_tdata[M_READ_HI:M_READ_LO] == '0)
        else $error("reading nonzero on timeout");

    // pad driven high only in the pulse, never while the send pin charges
    a_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[M_DRLV_BIT]
        |-> m_axis_tdata[M_DREN_BIT] && !m_axis_tdata[M_SEND_BIT])
        else $error("pad drive level without drive enable");

endmodule

bind capacitive_touch_timer ctt_checker u_ctt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> test/capacitive_touch_timer_tb.sv
// testbench for the capacitive touch timer: stream stimulus, tick predictor and result checks
module capacitive_touch_timer_tb;
    import ctt_pkg::*;

    localparam int TW          = TOTAL_WIDTH_DEF;
    localparam int STUCK_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 10;

    // predicts one result per tick and checks what comes out of the block
    class timer_scoreboard;
        logic [23:0]    timeout_limit;
        logic [15:0]    autocal_ms;
        logic [15:0]    discharge_len;
        t_phase         phase;
        logic [TW-1:0]  tick_total;
        logic [TW-1:0]  baseline;
        logic [7:0]     samples_left;
        logic [15:0]    phase_timer;
        logic [16:0]    ms_since_cal;
        t_result        pending_results[$];
        int             errors;
        int             items_taken;

        function new();
            timeout_limit = TIMEOUT_RST;
            autocal_ms    = AUTOCAL_RST;
            discharge_len = DISCHRG_RST;
            phase         = PH_IDLE;
            tick_total    = '0;
            baseline      = BASE_INIT_VALUE[TW-1:0];
            samples_left  = '0;
            phase_timer   = '0;
            ms_since_cal  = '0;
            errors        = 0;
            items_taken   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_TIMEOUT: timeout_limit = value;
                CFG_AUTOCAL: autocal_ms    = value[15:0];
                CFG_DISCHRG: discharge_len = value[15:0];
                default: ;
            endcase
        endfunction

        function bit limit_hit();
            return (tick_total >= TW'(timeout_limit)) || (tick_total == {TW{1'b1}});
        endfunction

        // baseline tracking on a clean finish, returns the reading
        function logic [TW-1:0] settle_baseline();
            logic [TW-1:0] diff;
            diff = (tick_total >= baseline) ? tick_total - baseline : baseline - tick_total;
            if (ms_since_cal > 17'(autocal_ms) && diff < baseline / 10) begin
                baseline     = BASE_INIT_VALUE[TW-1:0];
                ms_since_cal = '0;
            end
            if (tick_total < baseline)
                baseline = tick_total;
            return tick_total - baseline;
        endfunction

        function void take_tick(logic action, logic [7:0] count, logic rx, logic ms);
            t_result r;
            bit      timed_out;
            r         = '0;
            timed_out = 0;
            items_taken++;
            if (ms && ms_since_cal != MS_MAX)
                ms_since_cal++;
            case (phase)
                PH_IDLE: begin
                    if (action) begin
                        tick_total = '0;
                        if (count == 0) begin
                            r.done_res = 1'b1;
                        end else begin
                            samples_left = count;
                            phase_timer  = '0;
                            phase        = PH_DISCH;
                        end
                    end
                end
                PH_DISCH: begin
                    phase_timer++;
                    // a discharge length of zero acts like one tick
                    if (phase_timer >= discharge_len || phase_timer == 0)
                        phase = PH_CHARGE;
                end
                PH_CHARGE, PH_HIGH: begin
                    // charge counts while the pad is low, the high phase while it is high
                    if (limit_hit()) begin
                        timed_out = 1;
                    end else if (rx == (phase == PH_HIGH)) begin
                        tick_total++;
                        timed_out = limit_hit();
                    end else if (phase == PH_CHARGE) begin
                        phase = PH_PULSE;
                    end else begin
                        samples_left--;
                        if (samples_left == 0) begin
                            r.done_res = 1'b1;
                            r.reading  = READING_W'(settle_baseline());
                            phase      = PH_IDLE;
                        end else begin
                            phase_timer = '0;
                            phase       = PH_DISCH;
                        end
                    end
                    if (timed_out) begin
                        r.done_res = 1'b1;
                        r.status   = 1'b1;
                        phase      = PH_IDLE;
                    end
                end
                PH_PULSE: phase = PH_HIGH;
                default:  phase = PH_IDLE;
            endcase
            r.send_level      = (phase == PH_CHARGE);
            r.rx_drive_enable = (phase == PH_DISCH || phase == PH_PULSE);
            r.rx_drive_level  = (phase == PH_PULSE);
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void compare_result(logic [M_TDATA_W-1:0] got);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none got %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            check_field("send_level", want.send_level, got[M_SEND_BIT]);
            check_field("rx_drive_enable", want.rx_drive_enable, got[M_DREN_BIT]);
            check_field("rx_drive_level", want.rx_drive_level, got[M_DRLV_BIT]);
            check_field("done_res", want.done_res, got[M_DONE_BIT]);
            check_field("status", want.status, got[M_STAT_BIT]);
            check_field("reading", want.reading, got[M_READ_HI:M_READ_LO]);
        endfunction
    endclass

    typedef struct {
        logic [23:0] timeout_limit;
        logic [15:0] autocal_ms;
        logic [15:0] discharge_len;
    } t_setting;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    timer_scoreboard sb;
    bit              no_idle       = 1'b0;
    bit              ms_every_tick = 1'b0;
    int              stuck_cycles  = 0;

    t_setting plan[6] = '{
        '{24'd1000,     16'd0,     16'd1},
        '{24'd30,       16'd3,     16'd2},
        '{24'hFFFFFF,   16'hFFFF,  16'd3},
        '{24'd200,      16'd100,   16'd0},
        '{24'd12,       16'd1,     16'd1},
        '{TIMEOUT_RST,  AUTOCAL_RST, 16'd4}
    };

    capacitive_touch_timer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.compare_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // valid stays high from one item to the next unless an idle cycle comes in between
    task automatic send_tick(input logic action, input logic [7:0] count, input logic rx);
        logic [S_TDATA_W-1:0] data;
        logic                 ms;
        ms                = ms_every_tick || ($urandom_range(3) == 0);
        data              = '0;
        data[S_COUNT_LO +: 8] = count;
        data[S_RX_BIT]    = rx;
        data[S_MS_BIT]    = ms;
        while (!no_idle && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= action;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_tick(action, count, rx, ms);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_port(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    task automatic set_regs(input t_setting s);
        drain();
        write_port(CFG_TIMEOUT, s.timeout_limit);
        write_port(CFG_AUTOCAL, 24'(s.autocal_ms));
        write_port(CFG_DISCHRG, 24'(s.discharge_len));
        i_cfg_we <= 1'b0;
    endtask

    // start a measurement and play the pad so that each count phase lasts about run_len ticks
    task automatic run_measurement(input logic [7:0] count, input int unsigned run_len);
        t_phase      seen;
        int unsigned dwell;
        int unsigned cutoff;
        logic        rx;
        send_tick(1'b1, count, 1'($urandom_range(1)));
        seen   = sb.phase;
        dwell  = 0;
        cutoff = run_len;
        while (sb.phase != PH_IDLE) begin
            if (sb.phase != seen) begin
                seen   = sb.phase;
                dwell  = 0;
                cutoff = run_len + $urandom_range(2);
            end
            case (sb.phase)
                PH_CHARGE: rx = (dwell >= cutoff);
                PH_HIGH:   rx = (dwell < cutoff);
                default:   rx = 1'($urandom_range(1));
            endcase
            // an occasional glitch on the pad
            if ($urandom_range(19) == 0)
                rx = 1'($urandom_range(1));
            // starts while busy must be ignored
            send_tick(1'($urandom_range(15) == 0), 8'($urandom), rx);
            dwell++;
        end
    endtask

    initial begin
        int           start_items;
        logic [7:0]   count;
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_TIMEOUT;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: plain ticks, zero samples, one full sample
        send_tick(1'b0, 8'hFF, 1'b1);
        send_tick(1'b0, 8'h00, 1'b0);
        run_measurement(8'd0, 0);
        run_measurement(8'd1, 2);

        // shortest discharge, instant recal window, timeouts in the charge phase
        set_regs('{24'd60, 16'd0, 16'd0});
        run_measurement(8'd1, 0);
        run_measurement(8'd2, 3);
        run_measurement(8'd2, 3);
        run_measurement(8'd1, 80);
        run_measurement(8'd0, 0);

        // a zero limit ends the measurement on the first counting tick
        set_regs('{24'd0, 16'd5, 16'd1});
        run_measurement(8'd2, 3);

        foreach (plan[p]) begin
            no_idle = (p == 2);
            set_regs(plan[p]);
            start_items = sb.items_taken;
            while (sb.items_taken - start_items < 130) begin
                repeat ($urandom_range(3))
                    send_tick(1'b0, 8'($urandom), 1'($urandom_range(1)));
                count = (plan[p].timeout_limit <= 200) ? 8'($urandom)
                                                      : 8'($urandom_range(5));
                run_measurement(count, $urandom_range(12));
            end
        end

        // longest limit and recal interval, a millisecond on every tick
        no_idle = 1'b0;
        set_regs('{24'hFFFFFF, 16'hFFFF, 16'd5});
        no_idle       = 1'b1;
        ms_every_tick = 1'b1;
        run_measurement(8'd1, 4);
        no_idle       = 1'b0;
        ms_every_tick = 1'b0;

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
